[src/rzs_pkg.sv]
`timescale 1ns / 1ps
package rzs_pkg;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int PRICE_BITS_DEF = 24;

    localparam int WIN_W  = 9;
    localparam int THR_W  = 14;
    localparam int CFG_W  = 14;
    localparam int SIG_W  = 2;
    localparam int RSN_W  = 3;
    localparam int Z_W    = 32;

    localparam logic [WIN_W-1:0] WINDOW_RST    = 9'd20;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 14'd200;

    localparam logic REG_WINDOW    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [SIG_W-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd1;
    localparam logic [SIG_W-1:0] SIG_BUY  = 2'd2;

    localparam logic [RSN_W-1:0] RSN_ZERO_DEV = 3'd0;
    localparam logic [RSN_W-1:0] RSN_ABOVE    = 3'd1;
    localparam logic [RSN_W-1:0] RSN_BELOW    = 3'd2;
    localparam logic [RSN_W-1:0] RSN_WITHIN   = 3'd3;
    localparam logic [RSN_W-1:0] RSN_FEW      = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_OLD,
        ST_P_NEW,
        ST_P_WR,
        ST_E_MEAN,
        ST_E_NQ,
        ST_E_SS,
        ST_E_NN,
        ST_E_DIV1,
        ST_E_SQ1,
        ST_E_NP,
        ST_E_M2,
        ST_E_T2,
        ST_E_TV,
        ST_E_DIV2,
        ST_E_SQ2,
        ST_OUT
    } t_state;

endpackage

[src/rzs_ram.sv]
`timescale 1ns / 1ps
module rzs_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/rzs_smul.sv]
`timescale 1ns / 1ps
module rzs_smul #(
    parameter int AW = 66,
    parameter int BW = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_p
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_p;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // one multiplier bit per cycle, shift and add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= PW'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

[src/rzs_sdiv.sv]
`timescale 1ns / 1ps
module rzs_sdiv #(
    parameter int NW = 82,
    parameter int DW = 66
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

[src/rzs_ssqrt.sv]
`timescale 1ns / 1ps
module rzs_ssqrt #(
    parameter int NW = 82
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NW-1:0]   i_x,
    output logic            o_done,
    output logic [NW/2-1:0] o_root
);
    localparam int RW = NW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [NW-1:0] r_x;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW+3:0] tmp;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // two radicand bits in, one root bit out per cycle
    assign tmp   = {r_rem, r_x[NW-1:NW-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign diff  = tmp - trial;
    assign ge    = (tmp >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= ge ? diff[RW+1:0] : tmp[RW+1:0];
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[src/rolling_zscore_signal.sv]
`timescale 1ns / 1ps
// Push item: two bit-serial squarings (old and new sample) between accepts once the window is full;
// one while the window is still filling.
// Evaluate item: the bit-serial multiplier, divider and square-root units run in turn between
// accepts (skipped with too few samples, cut short at zero deviation); the result becomes valid in
// the same cycle that the next item can be taken, and an output stall on it holds the block.
// Synchronous active-low reset clears control, sums and fill count, window to 20
// and threshold to 200; the sample ring is not cleared.
module rolling_zscore_signal #(
    parameter int WINDOW_MAX = rzs_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = rzs_pkg::PRICE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [PRICE_BITS-1:0]      i_price,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [rzs_pkg::SIG_W-1:0]  o_signal,
    output logic [rzs_pkg::RSN_W-1:0]  o_reason,
    output logic signed [rzs_pkg::Z_W-1:0] o_z_hundredths,
    output logic [PRICE_BITS-1:0]      o_mean_cents,
    output logic [PRICE_BITS-1:0]      o_stddev_cents,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [rzs_pkg::CFG_W-1:0]  i_cfg_data
);
    import rzs_pkg::*;

    localparam int P   = PRICE_BITS;
    localparam int NB  = $clog2(WINDOW_MAX + 1);
    localparam int AB  = $clog2(WINDOW_MAX);
    localparam int SB  = P + NB;
    localparam int QB  = 2 * P + NB;
    localparam int VB  = 2 * SB;
    localparam int HB  = SB + 7;
    localparam int M2B = 2 * HB;
    localparam int TB  = 2 * THR_W;
    localparam int MA  = VB;
    localparam int MB  = (HB > TB) ? HB : TB;
    localparam int PW  = MA + MB;
    localparam int DNW = M2B + 2;
    localparam int DDW = VB;
    localparam int RW  = DNW / 2;
    localparam int ZW  = (RW + 1 > 33) ? RW + 1 : 33;

    t_state r_state, n_state;
    logic             r_started;
    logic [AB-1:0]    r_wi;
    logic [NB-1:0]    r_fill;
    logic [SB-1:0]    r_sum;
    logic [QB-1:0]    r_sq;
    logic [WIN_W-1:0] r_window;
    logic [THR_W-1:0] r_thr;
    logic [P-1:0]     r_price;
    logic [P-1:0]     r_mean;
    logic [VB-1:0]    r_nq;
    logic [VB-1:0]    r_v;
    logic [2*NB-1:0]  r_nn;
    logic             r_neg;
    logic [SB-1:0]    r_d;
    logic [M2B-1:0]   r_m2;
    logic [TB-1:0]    r_t2;
    logic             r_hit;
    logic [SIG_W-1:0] r_rsig;
    logic [RSN_W-1:0] r_rreason;
    logic [Z_W-1:0]   r_rz;
    logic [P-1:0]     r_rsd;
    logic             r_out_valid;
    logic [SIG_W-1:0] r_osig;
    logic [RSN_W-1:0] r_oreason;
    logic [Z_W-1:0]   r_oz;
    logic [P-1:0]     r_omean;
    logic [P-1:0]     r_osd;

    logic [NB-1:0]  n_eff;
    logic [AB+1:0]  old_sum;
    logic [AB-1:0]  old_addr;
    logic [P-1:0]   ram_rdata;
    logic           ram_we;
    logic           accept;
    logic           out_free;
    logic           is_mul, is_div, is_sqrt;
    logic           op_done;
    logic           mul_start, div_start, sqrt_start;
    logic [MA-1:0]  mul_a;
    logic [MB-1:0]  mul_b;
    logic [PW-1:0]  mul_p;
    logic           mul_done;
    logic [DNW-1:0] div_num;
    logic [DDW-1:0] div_den;
    logic [DNW-1:0] div_q;
    logic           div_done;
    logic [RW-1:0]  sqrt_root;
    logic           sqrt_done;
    logic [VB-1:0]  ss;
    logic [VB-1:0]  v_calc;
    logic [SB-1:0]  np;
    logic [HB-1:0]  hd;
    logic [RW:0]    rnd;
    logic [ZW-1:0]  rz;
    logic [Z_W-1:0] z_val;
    logic [P-1:0]   sd_val;

    assign n_eff = (r_window < WIN_W'(2)) ? NB'(2) :
                   ((32'(r_window) > WINDOW_MAX) ? NB'(WINDOW_MAX) : NB'(r_window));

    assign old_sum  = (AB+2)'(r_wi) + (AB+2)'(WINDOW_MAX) - (AB+2)'(n_eff);
    assign old_addr = (old_sum >= (AB+2)'(WINDOW_MAX)) ?
                      AB'(old_sum - (AB+2)'(WINDOW_MAX)) : AB'(old_sum);

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign ram_we   = (r_state == ST_P_WR);

    rzs_ram #(.W(P), .DEPTH(WINDOW_MAX)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wi),
        .i_wdata(r_price),
        .i_raddr(old_addr),
        .o_rdata(ram_rdata)
    );

    rzs_smul #(.AW(MA), .BW(MB)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    rzs_sdiv #(.NW(DNW), .DW(DDW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_q    (div_q)
    );

    rzs_ssqrt #(.NW(DNW)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sqrt_start),
        .i_x    (div_q),
        .o_done (sqrt_done),
        .o_root (sqrt_root)
    );

    assign ss     = mul_p[VB-1:0];
    assign v_calc = (r_nq > ss) ? (r_nq - ss) : '0;
    assign np     = mul_p[SB-1:0];
    assign hd     = (HB'(r_d) << 6) + (HB'(r_d) << 5) + (HB'(r_d) << 2);
    assign rnd    = ({1'b0, sqrt_root} + 1'b1) >> 1;
    assign rz     = ZW'(rnd);
    assign sd_val = P'(rnd);

    always_comb begin
        if (r_neg) begin
            z_val = (rz > ZW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - rz[Z_W-1:0]);
        end else begin
            z_val = (rz > ZW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rz[Z_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_PUSH) begin
                        n_state = (r_fill >= n_eff) ? ST_P_OLD : ST_P_NEW;
                    end else begin
                        n_state = (r_fill < n_eff) ? ST_OUT : ST_E_MEAN;
                    end
                end
            end
            ST_P_OLD:  if (r_started && op_done) n_state = ST_P_NEW;
            ST_P_NEW:  if (r_started && op_done) n_state = ST_P_WR;
            ST_P_WR:   n_state = ST_IDLE;
            ST_E_MEAN: if (r_started && op_done) n_state = ST_E_NQ;
            ST_E_NQ:   if (r_started && op_done) n_state = ST_E_SS;
            ST_E_SS: begin
                if (r_started && op_done) begin
                    n_state = (v_calc == '0) ? ST_OUT : ST_E_NN;
                end
            end
            ST_E_NN:   if (r_started && op_done) n_state = ST_E_DIV1;
            ST_E_DIV1: if (r_started && op_done) n_state = ST_E_SQ1;
            ST_E_SQ1:  if (r_started && op_done) n_state = ST_E_NP;
            ST_E_NP:   if (r_started && op_done) n_state = ST_E_M2;
            ST_E_M2:   if (r_started && op_done) n_state = ST_E_T2;
            ST_E_T2:   if (r_started && op_done) n_state = ST_E_TV;
            ST_E_TV:   if (r_started && op_done) n_state = ST_E_DIV2;
            ST_E_DIV2: if (r_started && op_done) n_state = ST_E_SQ2;
            ST_E_SQ2:  if (r_started && op_done) n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // unit control and operands
    always_comb begin
        is_mul  = (r_state inside {ST_P_OLD, ST_P_NEW, ST_E_NQ, ST_E_SS, ST_E_NN,
                                   ST_E_NP, ST_E_M2, ST_E_T2, ST_E_TV});
        is_div  = (r_state inside {ST_E_MEAN, ST_E_DIV1, ST_E_DIV2});
        is_sqrt = (r_state inside {ST_E_SQ1, ST_E_SQ2});
        op_done = (is_mul && mul_done) || (is_div && div_done) || (is_sqrt && sqrt_done);
        mul_start  = is_mul && !r_started;
        div_start  = is_div && !r_started;
        sqrt_start = is_sqrt && !r_started;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (r_state)
            ST_P_OLD: begin
                mul_a = MA'(ram_rdata);
                mul_b = MB'(ram_rdata);
            end
            ST_P_NEW: begin
                mul_a = MA'(r_price);
                mul_b = MB'(r_price);
            end
            ST_E_NQ: begin
                mul_a = MA'(r_sq);
                mul_b = MB'(n_eff);
            end
            ST_E_SS: begin
                mul_a = MA'(r_sum);
                mul_b = MB'(r_sum);
            end
            ST_E_NN: begin
                mul_a = MA'(n_eff);
                mul_b = MB'(n_eff);
            end
            ST_E_NP: begin
                mul_a = MA'(r_price);
                mul_b = MB'(n_eff);
            end
            ST_E_M2: begin
                mul_a = MA'(hd);
                mul_b = MB'(hd);
            end
            ST_E_T2: begin
                mul_a = MA'(r_thr);
                mul_b = MB'(r_thr);
            end
            ST_E_TV: begin
                mul_a = r_v;
                mul_b = MB'(r_t2);
            end
            ST_E_MEAN: begin
                div_num = DNW'({r_sum, 1'b0}) + DNW'(n_eff);
                div_den = DDW'({n_eff, 1'b0});
            end
            ST_E_DIV1: begin
                div_num = DNW'({r_v, 2'b00});
                div_den = DDW'(r_nn);
            end
            ST_E_DIV2: begin
                div_num = {r_m2, 2'b00};
                div_den = r_v;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_wi        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_window    <= WINDOW_RST;
            r_thr       <= THRESHOLD_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (is_mul || is_div || is_sqrt) begin
                if (!r_started) begin
                    r_started <= 1'b1;
                end else if (op_done) begin
                    r_started <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WINDOW: begin
                        r_window <= i_cfg_data[WIN_W-1:0];
                        r_wi     <= '0;
                        r_fill   <= '0;
                        r_sum    <= '0;
                        r_sq     <= '0;
                    end
                    REG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_started && mul_done && r_state == ST_P_OLD) begin
                r_sum <= r_sum - SB'(ram_rdata);
                r_sq  <= r_sq - mul_p[QB-1:0];
            end
            if (r_started && mul_done && r_state == ST_P_NEW) begin
                r_sum <= r_sum + SB'(r_price);
                r_sq  <= r_sq + mul_p[QB-1:0];
            end
            if (r_state == ST_P_WR) begin
                r_wi <= (r_wi == AB'(WINDOW_MAX - 1)) ? '0 : r_wi + 1'b1;
                if (r_fill < n_eff) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price   <= i_price;
            r_rsig    <= SIG_HOLD;
            r_rreason <= RSN_FEW;
            r_rz      <= '0;
            r_rsd     <= '0;
            r_mean    <= '0;
        end
        if (r_started && op_done) begin
            case (r_state)
                ST_E_MEAN: r_mean <= div_q[P-1:0];
                ST_E_NQ:   r_nq   <= mul_p[VB-1:0];
                ST_E_SS: begin
                    r_v       <= v_calc;
                    r_rreason <= RSN_ZERO_DEV;
                end
                ST_E_NN:   r_nn  <= mul_p[2*NB-1:0];
                ST_E_SQ1:  r_rsd <= sd_val;
                ST_E_NP: begin
                    r_neg <= (np < r_sum);
                    r_d   <= (np < r_sum) ? (r_sum - np) : (np - r_sum);
                end
                ST_E_M2:   r_m2  <= mul_p[M2B-1:0];
                ST_E_T2:   r_t2  <= mul_p[TB-1:0];
                ST_E_TV:   r_hit <= (PW'(r_m2) >= mul_p);
                ST_E_SQ2: begin
                    r_rz <= z_val;
                    if (!r_neg && r_hit) begin
                        r_rsig    <= SIG_SELL;
                        r_rreason <= RSN_ABOVE;
                    end else if ((r_neg || r_d == '0) && r_hit) begin
                        r_rsig    <= SIG_BUY;
                        r_rreason <= RSN_BELOW;
                    end else begin
                        r_rsig    <= SIG_HOLD;
                        r_rreason <= RSN_WITHIN;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == ST_OUT && out_free) begin
            r_osig    <= r_rsig;
            r_oreason <= r_rreason;
            r_oz      <= r_rz;
            r_omean   <= r_mean;
            r_osd     <= r_rsd;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_signal       = r_osig;
    assign o_reason       = r_oreason;
    assign o_z_hundredths = r_oz;
    assign o_mean_cents   = r_omean;
    assign o_stddev_cents = r_osd;
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import rzs_pkg::*;

    localparam int  LIMIT_CYCLES = 6000000;
    localparam int  SETTLE       = 800;
    localparam int  NPHASE       = 8;

    typedef struct packed {
        logic        act;
        logic [23:0] price;
    } t_tick;

    typedef struct packed {
        logic [SIG_W-1:0] sig;
        logic [RSN_W-1:0] rsn;
        logic [Z_W-1:0]   z;
        logic [23:0]      mean;
        logic [23:0]      sd;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic act = ACT_PUSH;
    logic [23:0] price = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SIG_W-1:0] sig;
    logic [RSN_W-1:0] rsn;
    logic signed [Z_W-1:0] z;
    logic [23:0] mean_c;
    logic [23:0] sd_c;
    logic cfg_we = 1'b0;
    logic cfg_idx = REG_WINDOW;
    logic [CFG_W-1:0] cfg_data = '0;

    rolling_zscore_signal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(act), .i_price(price),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_signal(sig), .o_reason(rsn), .o_z_hundredths(z),
        .o_mean_cents(mean_c), .o_stddev_cents(sd_c),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // price history mirror
    logic [23:0] ring [256];
    logic [7:0]  widx = '0;
    logic [8:0]  fill = '0;
    logic [63:0] sum = '0;
    logic [63:0] sumsq = '0;
    logic [8:0]  win = WINDOW_RST;
    logic [13:0] thr = THRESHOLD_RST;

    t_tick    pend[$];
    t_verdict verdicts[$];
    int       cyc = 0;
    int       errs = 0;
    int       n_push = 0;
    int       n_eval = 0;
    int       rsn_seen[5] = '{default: 0};
    int       base = 0;
    int       spread = 0;

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [127:0] res, b, t;
        res = '0;
        b = 128'(1) << 126;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            t = res + b;
            if (x >= t) begin
                x = x - t;
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[63:0];
    endfunction

    function automatic logic [127:0] span();
        if (win < 2) return 128'd2;
        if (win > 256) return 128'd256;
        return 128'(win);
    endfunction

    function automatic t_verdict score(input logic [23:0] p);
        logic [127:0] nn, v, s2, m2, tv;
        logic [63:0] np, d, r;
        logic neg, hit;
        t_verdict o;
        nn = span();
        o = '0;
        if (128'(fill) < nn) begin
            o.rsn = RSN_FEW;
            return o;
        end
        o.mean = 24'((128'(sum) * 2 + nn) / (nn * 2));
        v = nn * 128'(sumsq);
        s2 = 128'(sum) * 128'(sum);
        v = (v > s2) ? v - s2 : '0;
        if (v == 0) begin
            o.rsn = RSN_ZERO_DEV;
            return o;
        end
        o.sd = 24'((isqrt((v << 2) / (nn * nn)) + 1) >> 1);
        np = 64'(nn) * 64'(p);
        neg = np < sum;
        d = neg ? sum - np : np - sum;
        m2 = (128'(d) * 100) * (128'(d) * 100);
        tv = 128'(thr) * 128'(thr) * v;
        hit = m2 >= tv;
        if (!neg && hit) begin
            o.sig = SIG_SELL;
            o.rsn = RSN_ABOVE;
        end else if ((neg || d == 0) && hit) begin
            o.sig = SIG_BUY;
            o.rsn = RSN_BELOW;
        end else begin
            o.sig = SIG_HOLD;
            o.rsn = RSN_WITHIN;
        end
        r = (isqrt((m2 << 2) / v) + 1) >> 1;
        if (neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            o.z = 32'(-r);
        end else begin
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            o.z = r[31:0];
        end
        return o;
    endfunction

    task automatic absorb(input logic [23:0] p);
        logic [63:0] old;
        if (128'(fill) >= span()) begin
            old = 64'(ring[8'(widx - 8'(span()))]);
            sum = sum - old;
            sumsq = sumsq - old * old;
        end else begin
            fill = fill + 1;
        end
        ring[widx] = p;
        sum = sum + 64'(p);
        sumsq = sumsq + 64'(p) * 64'(p);
        widx = widx + 1;
    endtask

    // mirror update on register writes and accepted items
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_we) begin
            if (cfg_idx == REG_WINDOW) begin
                win <= cfg_data[8:0];
                widx <= '0;
                fill <= '0;
                sum <= '0;
                sumsq <= '0;
            end else begin
                thr <= cfg_data[13:0];
            end
        end
        if (i_rst_n && in_valid && !in_stall) begin
            if (act == ACT_PUSH) begin
                absorb(price);
                n_push <= n_push + 1;
            end else begin
                verdicts = {verdicts, score(price)};
                n_eval <= n_eval + 1;
            end
        end
    end

    function automatic bit calm();
        return (cyc % 40000) < 6000;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pend.size() > 0 && (calm() || $urandom_range(99) >= 23)) begin
                in_valid <= 1'b1;
                act <= pend[0].act;
                price <= pend[0].price;
                void'(pend.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else out_stall <= !calm() && ($urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        t_verdict w;
        if (i_rst_n && out_valid && !out_stall) begin
            if (verdicts.size() == 0) begin
                errs <= errs + 1;
                if (errs < 10) $display("unexpected result at cycle %0d", cyc);
            end else begin
                w = verdicts.pop_front();
                if (rsn <= RSN_FEW) rsn_seen[rsn] <= rsn_seen[rsn] + 1;
                if (sig !== w.sig || rsn !== w.rsn || z !== w.z
                        || mean_c !== w.mean || sd_c !== w.sd) begin
                    errs <= errs + 1;
                    if (errs < 10)
                        $display({"mismatch: exp sig %0d rsn %0d z %0d mean %0d sd %0d",
                            " / got %0d %0d %0d %0d %0d"},
                            w.sig, w.rsn, $signed(w.z), w.mean, w.sd,
                            sig, rsn, z, mean_c, sd_c);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic add(input logic a, input logic [23:0] p);
        t_tick t;
        t.act = a;
        t.price = p;
        pend = {pend, t};
    endtask

    task automatic drain();
        while (pend.size() != 0 || in_valid || verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick(input bit ev);
        longint off, v;
        if (spread < 0) return 24'($urandom);
        off = longint'($urandom_range(2 * spread)) - spread;
        if (ev) off = off * $urandom_range(6);
        v = base + off;
        if (v < 0) v = 0;
        if (v > 24'hFFFFFF) v = 24'hFFFFFF;
        return 24'(v);
    endfunction

    task automatic reroll();
        int k;
        k = $urandom_range(9);
        spread = (k == 0) ? 0 : (k < 3) ? 3 : (k < 6) ? 100 : (k < 8) ? 5000 : -1;
        if ($urandom_range(3) == 0) base = $urandom_range(24'hFFFFFF);
    endtask

    int win_set[NPHASE] = '{5, 256, 0, 1, 20, 511, 8, 2};
    int thr_set[NPHASE] = '{200, 100, 1, 10000, 16383, 0, 50, 300};

    initial begin
        int fillc;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // too few samples at reset window
        add(ACT_EVAL, 24'd1000);
        add(ACT_PUSH, 24'd5);
        add(ACT_EVAL, 24'd5);
        drain();
        write_reg(REG_WINDOW, 14'd2);
        add(ACT_PUSH, 24'd0);
        add(ACT_EVAL, 24'd0);
        add(ACT_PUSH, 24'hFFFFFF);
        add(ACT_EVAL, 24'hFFFFFF);
        add(ACT_EVAL, 24'd0);
        add(ACT_EVAL, 24'h7FFFFF);
        add(ACT_EVAL, 24'h800000);
        add(ACT_PUSH, 24'hFFFFFF);
        add(ACT_EVAL, 24'hFFFFFF);
        add(ACT_EVAL, 24'd0);
        add(ACT_PUSH, 24'd100);
        add(ACT_PUSH, 24'd300);
        add(ACT_EVAL, 24'd200);
        drain();
        // threshold zero: a z of zero counts as a sell
        write_reg(REG_THRESHOLD, 14'd0);
        add(ACT_EVAL, 24'd200);
        add(ACT_EVAL, 24'd201);
        add(ACT_EVAL, 24'd199);
        drain();

        for (int ph = 0; ph < NPHASE; ph++) begin
            write_reg(REG_WINDOW, 14'(win_set[ph]));
            write_reg(REG_THRESHOLD, 14'(thr_set[ph]));
            base = $urandom_range(24'hFFFFFF);
            reroll();
            fillc = (win_set[ph] < 2) ? 2 : (win_set[ph] > 256) ? 256 : win_set[ph];
            add(ACT_EVAL, pick(1));
            for (int i = 0; i < fillc; i++) add(ACT_PUSH, pick(0));
            for (int i = 0; i < 120; i++) begin
                if (i % 30 == 29) reroll();
                if ($urandom_range(99) < 35) add(ACT_EVAL, pick(1));
                else add(ACT_PUSH, pick(0));
            end
            drain();
        end

        $display("run: %0d pushes, %0d evaluations over %0d register settings", n_push, n_eval,
            NPHASE + 2);
        $display("reasons: zero-dev %0d above %0d below %0d within %0d few %0d", rsn_seen[0],
            rsn_seen[1], rsn_seen[2], rsn_seen[3], rsn_seen[4]);
        if (errs == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
